[src/sps_pkg.sv]
// ----------------------------------------------------------------------------
// Servo pulse sequencer package
// Shared constants, command codes, register indexes and the control and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sps_pkg;

   // Default build parameters.
   localparam int DEF_CHANNELS   = 7;
   localparam int DEF_WIDTH_BITS = 10;

   // Fixed field widths of the ports.
   localparam int KIND_W    = 3;
   localparam int CH_W      = 3;
   localparam int VALUE_W   = 11;
   localparam int COUNT_W   = 3;
   localparam int MASK_W    = 7;
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 3;
   localparam int PINS_W    = 7;

   // Pulse and step constants.
   localparam int PULSE_EXTRA = 20;
   localparam int STEP_SIZE   = 1;

   // Angle conversion arithmetic widths.
   localparam int PROD_BITS = 2 * VALUE_W;
   localparam int MAG_BITS  = PROD_BITS - 1;
   localparam int DIV_STEPS = MAG_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int SUM_BITS  = MAG_BITS + 2;
   localparam int CMP_BITS  = 17;

   // Command codes.
   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ANGLE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UP     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DOWN   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CENTER = 3'd6;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN   = 3'd5;

   // Register reset values.
   localparam logic [COUNT_W-1:0] RST_COUNT  = 3'd2;
   localparam logic [MASK_W-1:0]  RST_MASK   = 7'd0;
   localparam logic [CFG_W-1:0]   RST_MIN    = 10'd100;
   localparam logic [CFG_W-1:0]   RST_MAX    = 10'd200;
   localparam logic [CFG_W-1:0]   RST_CENTER = 10'd150;
   localparam logic [CFG_W-1:0]   RST_SPAN   = 10'd180;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic load_rd;
      logic mul;
      logic div_step;
      logic commit;
   } sps_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
   } sps_status_type;

endpackage

[src/sps_ctrl.sv]
// ----------------------------------------------------------------------------
// Servo pulse sequencer controller
// Sequences one command beat through load, multiply and divide when an angle
// beat needs them, and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sps_pkg::sps_cmd_type    cmd,
   input  sps_pkg::sps_status_type status
);
   import sps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic                   rsp_valid_ff;
   logic                   out_free;

   // The result register can take a new beat when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands decoded from the current state.
   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.load_rd  = (state_ff == ST_LOAD);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.commit   = (state_ff == ST_FINISH) && out_free;
   end

   // State, divider step counter and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A committed beat refills the result register; otherwise it empties
         // once the receiver takes it.
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= status.need_div ? ST_MUL : ST_FINISH;
            end
            ST_MUL: begin
               cnt_ff   <= DIV_CNT_W'(DIV_STEPS - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[src/sps_dp.sv]
// ----------------------------------------------------------------------------
// Servo pulse sequencer datapath
// Configuration registers, channel widths, frame counters, the angle
// multiplier with its restoring divider, and the result register.
// ----------------------------------------------------------------------------
module sps_dp #(
   parameter int CHANNELS   = sps_pkg::DEF_CHANNELS,
   parameter int WIDTH_BITS = sps_pkg::DEF_WIDTH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sps_pkg::sps_cmd_type                cmd,
   output sps_pkg::sps_status_type             status,
   input  logic [sps_pkg::KIND_W-1:0]          req_kind,
   input  logic [sps_pkg::CH_W-1:0]            req_channel,
   input  logic signed [sps_pkg::VALUE_W-1:0]  req_value,
   input  logic                                csr_we,
   input  logic [sps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sps_pkg::CFG_W-1:0]           csr_wdata,
   output logic [sps_pkg::PINS_W-1:0]          rsp_pulse_pins,
   output logic                                rsp_busy_res,
   output logic                                rsp_frame_done
);
   import sps_pkg::*;

   localparam int TICK_BITS = WIDTH_BITS + 1;
   localparam logic signed [SUM_BITS-1:0] WIDTH_TOP = SUM_BITS'((1 << WIDTH_BITS) - 1);

   // Clamp a signed value into the width range.
   function automatic logic [WIDTH_BITS-1:0] sat_width(input logic signed [SUM_BITS-1:0] v);
      logic [WIDTH_BITS-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > WIDTH_TOP) begin
         r = WIDTH_TOP[WIDTH_BITS-1:0];
      end else begin
         r = v[WIDTH_BITS-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [COUNT_W-1:0] count_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [CFG_W-1:0]   wmin_ff;
   logic [CFG_W-1:0]   wmax_ff;
   logic [CFG_W-1:0]   wcenter_ff;
   logic [CFG_W-1:0]   span_ff;

   // Captured command beat.
   logic [KIND_W-1:0]         kind_ff;
   logic [CH_W-1:0]           ch_ff;
   logic signed [VALUE_W-1:0] value_ff;

   // Channel widths and frame state.
   logic [WIDTH_BITS-1:0] widths_ff [CHANNELS];
   logic [WIDTH_BITS-1:0] rd_ff;
   logic [CH_W-1:0]       active_ff;
   logic [TICK_BITS-1:0]  ticks_ff;
   logic                  frame_ff;

   // Divider registers.
   logic [CFG_W-1:0]    rem_ff;
   logic [MAG_BITS-1:0] quo_ff;
   logic                neg_ff;

   // Result register.
   logic [PINS_W-1:0] pins_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [COUNT_W-1:0]          used_ch;
   logic                        ch_ok;
   logic [CH_W-1:0]             rd_addr;
   logic [WIDTH_BITS-1:0]       rd_word;
   logic signed [VALUE_W-1:0]   diff;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [PROD_BITS-1:0] prod_abs;
   logic [CFG_W:0]              trial;
   logic [CFG_W:0]              trial_sub;
   logic                        fits;
   logic signed [SUM_BITS-1:0]  quo_ext;
   logic signed [SUM_BITS-1:0]  term;
   logic signed [SUM_BITS-1:0]  center_ext;
   logic signed [SUM_BITS-1:0]  angle_sum;
   logic signed [SUM_BITS-1:0]  mir;
   logic [MASK_W:0]             rev_bits;
   logic [WIDTH_BITS-1:0]       pulse_w;
   logic [TICK_BITS-1:0]        plen;
   logic [CMP_BITS-1:0]         up_v;
   logic [CMP_BITS-1:0]         dn_v;
   logic                        up_ok;
   logic                        dn_ok;
   logic [CH_W:0]               nxt_ch;
   logic [TICK_BITS-1:0]        tick_dec;
   logic                        frame_in;
   logic [CH_W-1:0]             active_in;
   logic [TICK_BITS-1:0]        ticks_in;
   logic                        done_in;
   logic [PINS_W-1:0]           pins_in;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= RST_COUNT;
         mask_ff    <= RST_MASK;
         wmin_ff    <= RST_MIN;
         wmax_ff    <= RST_MAX;
         wcenter_ff <= RST_CENTER;
         span_ff    <= RST_SPAN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNT:  count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_MASK:   mask_ff    <= csr_wdata[MASK_W-1:0];
            CSR_MIN:    wmin_ff    <= csr_wdata;
            CSR_MAX:    wmax_ff    <= csr_wdata;
            CSR_CENTER: wcenter_ff <= csr_wdata;
            CSR_SPAN:   span_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the accepted command beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         ch_ff    <= req_channel;
         value_ff <= req_value;
      end
   end

   // Channels in a frame, limited to what is built.
   assign used_ch = (int'(count_ff) > CHANNELS) ? COUNT_W'(CHANNELS) : count_ff;
   assign ch_ok   = int'(ch_ff) < CHANNELS;

   // Single read port: the next channel for ticks, channel zero for start,
   // otherwise the addressed channel.
   always_comb begin
      case (kind_ff)
         KIND_TICK:  rd_addr = active_ff + 1'b1;
         KIND_START: rd_addr = '0;
         default:    rd_addr = ch_ff;
      endcase
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (int'(rd_addr) == i) begin
            rd_word = widths_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rd) begin
         rd_ff <= rd_word;
      end
   end

   assign status.need_div = (kind_ff == KIND_ANGLE) && ch_ok && (span_ff != '0);

   // Angle product: value times the width range.
   assign diff     = $signed({1'b0, wmax_ff}) - $signed({1'b0, wmin_ff});
   assign prod     = PROD_BITS'(value_ff) * PROD_BITS'(diff);
   assign prod_abs = prod[PROD_BITS-1] ? -prod : prod;

   // One restoring divide step per cycle on the product magnitude.
   assign trial     = {rem_ff, quo_ff[MAG_BITS-1]};
   assign fits      = trial >= {1'b0, span_ff};
   assign trial_sub = trial - {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_rd) begin
         rem_ff <= '0;
         quo_ff <= '0;
         neg_ff <= 1'b0;
      end else if (cmd.mul) begin
         rem_ff <= '0;
         quo_ff <= prod_abs[MAG_BITS-1:0];
         neg_ff <= prod[PROD_BITS-1];
      end else if (cmd.div_step) begin
         rem_ff <= fits ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
         quo_ff <= {quo_ff[MAG_BITS-2:0], fits};
      end
   end

   // Signed quotient, truncated toward zero, plus the center width.
   assign quo_ext    = {2'b00, quo_ff};
   assign term       = neg_ff ? -quo_ext : quo_ext;
   assign center_ext = SUM_BITS'(wcenter_ff);
   assign angle_sum  = term + center_ext;

   // Pulse length of the channel just read, mirrored when reversed.
   assign mir      = SUM_BITS'(wmax_ff) + SUM_BITS'(wmin_ff) - SUM_BITS'(rd_ff);
   assign rev_bits = {1'b0, mask_ff};
   assign pulse_w  = rev_bits[rd_addr] ? sat_width(mir) : rd_ff;
   assign plen     = TICK_BITS'(pulse_w) + TICK_BITS'(PULSE_EXTRA);

   // Step limits.
   assign up_v  = CMP_BITS'(rd_ff) + CMP_BITS'(STEP_SIZE);
   assign dn_v  = CMP_BITS'(rd_ff) - CMP_BITS'(STEP_SIZE);
   assign up_ok = (up_v <= CMP_BITS'(wmax_ff)) && (up_v <= CMP_BITS'(WIDTH_TOP));
   assign dn_ok = (CMP_BITS'(rd_ff) >= CMP_BITS'(STEP_SIZE)) && (dn_v >= CMP_BITS'(wmin_ff));

   // Frame sequencing for tick and start commands.
   assign nxt_ch   = {1'b0, active_ff} + 1'b1;
   assign tick_dec = (ticks_ff != '0) ? ticks_ff - 1'b1 : ticks_ff;

   always_comb begin
      frame_in  = frame_ff;
      active_in = active_ff;
      ticks_in  = ticks_ff;
      done_in   = 1'b0;
      case (kind_ff)
         KIND_TICK: begin
            if (frame_ff) begin
               ticks_in = tick_dec;
               if (tick_dec == '0) begin
                  if (nxt_ch >= {1'b0, used_ch}) begin
                     frame_in  = 1'b0;
                     active_in = '0;
                     done_in   = 1'b1;
                  end else begin
                     active_in = nxt_ch[CH_W-1:0];
                     ticks_in  = plen;
                  end
               end
            end
         end
         KIND_START: begin
            if (!frame_ff && (used_ch != '0)) begin
               frame_in  = 1'b1;
               active_in = '0;
               ticks_in  = plen;
            end
         end
         default: ;
      endcase
   end

   assign pins_in = frame_in ? (PINS_W'(1) << active_in) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= 1'b0;
         active_ff <= '0;
         ticks_ff  <= '0;
      end else if (cmd.commit) begin
         frame_ff  <= frame_in;
         active_ff <= active_in;
         ticks_ff  <= ticks_in;
      end
   end

   // Width updates at commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            widths_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < CHANNELS; i++) begin
            case (kind_ff)
               KIND_SET: begin
                  if (int'(ch_ff) == i) begin
                     widths_ff[i] <= sat_width(SUM_BITS'(value_ff));
                  end
               end
               KIND_ANGLE: begin
                  if (int'(ch_ff) == i) begin
                     widths_ff[i] <= sat_width(angle_sum);
                  end
               end
               KIND_UP: begin
                  if ((int'(ch_ff) == i) && up_ok) begin
                     widths_ff[i] <= up_v[WIDTH_BITS-1:0];
                  end
               end
               KIND_DOWN: begin
                  if ((int'(ch_ff) == i) && dn_ok) begin
                     widths_ff[i] <= dn_v[WIDTH_BITS-1:0];
                  end
               end
               KIND_CENTER: begin
                  if (i < int'(used_ch)) begin
                     widths_ff[i] <= sat_width(center_ext);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pins_ff <= pins_in;
         busy_ff <= frame_in;
         done_ff <= done_in;
      end
   end

   assign rsp_pulse_pins = pins_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_frame_done = done_ff;

endmodule

[src/servo_pulse_sequencer.sv]
// ----------------------------------------------------------------------------
// Servo pulse sequencer
// Multi-channel RC servo pulse generator: per-channel widths, angle
// conversion, stepping, centering and framed pulse output.
//
//   Port group   Direction   Handshake          Beat contents
//   req_         in          valid / stall      kind, channel, value
//   rsp_         out         valid / stall      pulse_pins, busy_res, frame_done
//   csr_         in          write enable       index, write data
//
// Each beat passes load and finish before the next accept; an angle beat on a
// built channel, span nonzero, adds multiply and a 21-step restoring divider.
// The result register frees the input side: a new beat is accepted while the
// last result still waits, and the block holds before commit until it drains.
// Reset is synchronous; it loads the register defaults and clears the widths.
// ----------------------------------------------------------------------------
module servo_pulse_sequencer #(
   parameter int CHANNELS   = sps_pkg::DEF_CHANNELS,
   parameter int WIDTH_BITS = sps_pkg::DEF_WIDTH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sps_pkg::KIND_W-1:0]          req_kind,
   input  logic [sps_pkg::CH_W-1:0]            req_channel,
   input  logic signed [sps_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sps_pkg::PINS_W-1:0]          rsp_pulse_pins,
   output logic                                rsp_busy_res,
   output logic                                rsp_frame_done,
   input  logic                                csr_we,
   input  logic [sps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sps_pkg::CFG_W-1:0]           csr_wdata
);
   import sps_pkg::*;

   sps_cmd_type    cmd;
   sps_status_type status;

   // Command sequencing.
   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Storage and arithmetic.
   sps_dp #(
      .CHANNELS   (CHANNELS),
      .WIDTH_BITS (WIDTH_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_channel    (req_channel),
      .req_value      (req_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_pulse_pins (rsp_pulse_pins),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done)
   );

`ifndef ASSERT_OFF
   // Pins are only driven while a frame is running.
   a_pins_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |-> (rsp_pulse_pins == '0))
      else $error("pulse pin high outside a frame");

   // At most one channel pulses at a time.
   a_pins_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_pulse_pins))
      else $error("more than one pulse pin high");

   // The beat that ends a frame reports the frame as over.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> !rsp_busy_res)
      else $error("frame done while still busy");

   // An accepted beat is never committed in the cycle right after accept.
   a_accept_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !cmd.commit))
      else $error("command committed without a load cycle");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Servo pulse sequencer testbench
// Drives command beats into the sequencer and checks every result beat
// against a cycle-free model of the channel widths and the pulse frame.
// A directed opening covers the field extremes and corner commands. Then
// several register settings follow, most with short frames whose ticks are
// counted out from the model, mixed with random command noise. Both sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sps_pkg::*;

   localparam int          N_CH        = DEF_CHANNELS;
   localparam int          WIDTH_TOP   = (1 << DEF_WIDTH_BITS) - 1;
   localparam int          IDLE_PCT    = 14;
   localparam int          HOLD_CYCLES = 300;
   localparam int          PHASE_BEATS = 80;
   localparam int          CYCLE_LIMIT = 600000;
   localparam logic [2:0]  KIND_UNUSED = 3'd7;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic [CH_W-1:0]           chan;
      logic signed [VALUE_W-1:0] value;
   } servo_cmd_type;

   typedef struct {
      logic [PINS_W-1:0] pins;
      logic              busy;
      logic              fin;
   } servo_out_type;

   // Clock, reset and block ports.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [KIND_W-1:0]         req_kind = '0;
   logic [CH_W-1:0]           req_channel = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [PINS_W-1:0]         rsp_pulse_pins;
   logic                      rsp_busy_res;
   logic                      rsp_frame_done;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CFG_W-1:0]          csr_wdata = '0;

   // Model of the register file.
   logic [COUNT_W-1:0] m_count  = RST_COUNT;
   logic [MASK_W-1:0]  m_mask   = RST_MASK;
   logic [CFG_W-1:0]   m_min    = RST_MIN;
   logic [CFG_W-1:0]   m_max    = RST_MAX;
   logic [CFG_W-1:0]   m_center = RST_CENTER;
   logic [CFG_W-1:0]   m_span   = RST_SPAN;

   // Model of the widths and the frame.
   logic [DEF_WIDTH_BITS-1:0] m_width [N_CH] = '{default: '0};
   logic [CH_W-1:0]           m_chan  = '0;
   logic [10:0]               m_ticks = '0;
   logic                      m_busy  = 1'b0;

   servo_cmd_type beat_q [$];
   servo_out_type pins_expect_q [$];
   servo_cmd_type taken_beat;
   servo_cmd_type next_beat;
   servo_out_type predicted;
   servo_out_type wanted;

   int  n_pushed  = 0;
   int  n_taken   = 0;
   int  n_errors  = 0;
   int  cycles    = 0;
   int  hold_left = 0;
   bit  hold_arm  = 1'b0;
   bit  hold_used = 1'b0;

   servo_pulse_sequencer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_channel    (req_channel),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pulse_pins (rsp_pulse_pins),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Servo model
   // ------------------------------------------------------------------------

   function automatic logic [DEF_WIDTH_BITS-1:0] clip_width(input int v);
      if (v < 0) return '0;
      if (v > WIDTH_TOP) return DEF_WIDTH_BITS'(WIDTH_TOP);
      return DEF_WIDTH_BITS'(v);
   endfunction

   function automatic int used_ch();
      return (int'(m_count) > N_CH) ? N_CH : int'(m_count);
   endfunction

   // Pulse length of one channel; reversed channels mirror their width
   // inside the min/max window.
   function automatic int pulse_len(input int ch);
      int w;
      w = m_width[ch];
      if (ch < PINS_W && m_mask[ch]) w = clip_width(int'(m_max) - w + int'(m_min));
      return w + PULSE_EXTRA;
   endfunction

   // Ticks still needed to close the running frame, assuming no width changes.
   function automatic int frame_ticks_left();
      int r;
      if (!m_busy) return 0;
      r = m_ticks;
      for (int ch = int'(m_chan) + 1; ch < used_ch(); ch++) r += pulse_len(ch);
      return r;
   endfunction

   task automatic servo_apply(input servo_cmd_type c, output servo_out_type o);
      int v;
      int ch;
      int term;
      int nxt;
      bit fin;
      v   = c.value;
      ch  = c.chan;
      fin = 1'b0;
      case (c.kind)
         KIND_TICK: begin
            if (m_busy) begin
               if (m_ticks > 0) m_ticks--;
               if (m_ticks == 0) begin
                  if (int'(m_chan) + 1 >= used_ch()) begin
                     m_busy = 1'b0;
                     m_chan = '0;
                     fin    = 1'b1;
                  end else begin
                     m_chan++;
                     m_ticks = 11'(pulse_len(m_chan));
                  end
               end
            end
         end
         KIND_START: begin
            if (!m_busy && used_ch() > 0) begin
               m_busy  = 1'b1;
               m_chan  = '0;
               m_ticks = 11'(pulse_len(0));
            end
         end
         KIND_SET: begin
            if (ch < N_CH) m_width[ch] = clip_width(v);
         end
         KIND_ANGLE: begin
            if (ch < N_CH) begin
               term = 0;
               if (m_span != 0) term = (v * (int'(m_max) - int'(m_min))) / int'(m_span);
               m_width[ch] = clip_width(term + int'(m_center));
            end
         end
         KIND_UP: begin
            if (ch < N_CH) begin
               nxt = int'(m_width[ch]) + STEP_SIZE;
               if (nxt <= int'(m_max) && nxt <= WIDTH_TOP)
                  m_width[ch] = DEF_WIDTH_BITS'(nxt);
            end
         end
         KIND_DOWN: begin
            if (ch < N_CH) begin
               nxt = int'(m_width[ch]) - STEP_SIZE;
               if (nxt >= int'(m_min) && nxt >= 0) m_width[ch] = DEF_WIDTH_BITS'(nxt);
            end
         end
         KIND_CENTER: begin
            for (int i = 0; i < used_ch(); i++) m_width[i] = clip_width(int'(m_center));
         end
         default: begin
         end
      endcase
      o.pins = m_busy ? (PINS_W'(1) << m_chan) : '0;
      o.busy = m_busy;
      o.fin  = fin;
   endtask

   // ------------------------------------------------------------------------
   // Command side
   // ------------------------------------------------------------------------

   // No idling for a long stretch in the middle of the run.
   function automatic bit calm();
      return n_taken >= 700 && n_taken < 1000;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // Predict the beat that the block takes at this edge.
         if (req_valid && !req_stall) begin
            taken_beat.kind  = req_kind;
            taken_beat.chan  = req_channel;
            taken_beat.value = req_value;
            servo_apply(taken_beat, predicted);
            pins_expect_q.push_back(predicted);
            n_taken++;
         end
         // Offer the next beat once the current one is gone.
         if (!req_valid || !req_stall) begin
            if (beat_q.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
               next_beat = beat_q.pop_front();
               req_valid   <= 1'b1;
               req_kind    <= next_beat.kind;
               req_channel <= next_beat.chan;
               req_value   <= next_beat.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Random stalls, plus one long hold-off while a frame stream is queued.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_arm && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm() && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic note_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      n_errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pins_expect_q.size() == 0) begin
            note_mismatch("result beat with nothing expected");
         end else begin
            wanted = pins_expect_q.pop_front();
            if (rsp_pulse_pins !== wanted.pins)
               note_mismatch($sformatf("pulse_pins %b, expected %b", rsp_pulse_pins,
                                       wanted.pins));
            if (rsp_busy_res !== wanted.busy)
               note_mismatch($sformatf("busy_res %b, expected %b", rsp_busy_res, wanted.busy));
            if (rsp_frame_done !== wanted.fin)
               note_mismatch($sformatf("frame_done %b, expected %b", rsp_frame_done,
                                       wanted.fin));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic queue_beat(input logic [KIND_W-1:0] k, input int ch, input int v);
      servo_cmd_type c;
      c.kind  = k;
      c.chan  = ch[CH_W-1:0];
      c.value = v[VALUE_W-1:0];
      beat_q.push_back(c);
      n_pushed++;
   endtask

   // Ticks carry random channel and value bits; the block ignores them.
   task automatic queue_tick();
      queue_beat(KIND_TICK, $urandom_range(0, 7), $urandom_range(0, 2047));
   endtask

   // Wait until every queued beat has been taken and answered.
   task automatic wait_quiet();
      while (n_taken != n_pushed || pins_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CFG_W-1:0];
   endtask

   task automatic set_config(input int cnt, input int mask, input int lo, input int hi,
                             input int mid, input int span);
      m_count  = cnt[COUNT_W-1:0];
      m_mask   = mask[MASK_W-1:0];
      m_min    = lo[CFG_W-1:0];
      m_max    = hi[CFG_W-1:0];
      m_center = mid[CFG_W-1:0];
      m_span   = span[CFG_W-1:0];
      write_csr(CSR_COUNT, cnt);
      write_csr(CSR_MASK, mask);
      write_csr(CSR_MIN, lo);
      write_csr(CSR_MAX, hi);
      write_csr(CSR_CENTER, mid);
      write_csr(CSR_SPAN, span);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // A command that may land in the middle of a frame; set widths stay small.
   task automatic queue_mid_cmd();
      int s;
      s = m_span;
      case ($urandom_range(0, 8))
         0: queue_beat(KIND_START, $urandom_range(0, 7), $urandom_range(0, 2047));
         1: queue_beat(KIND_SET, $urandom_range(0, 7), $urandom_range(0, 40));
         2: queue_beat(KIND_ANGLE, $urandom_range(0, 7), $urandom_range(0, 2 * s) - s);
         3: queue_beat(KIND_UP, $urandom_range(0, 7), $urandom_range(0, 2047));
         4: queue_beat(KIND_DOWN, $urandom_range(0, 7), $urandom_range(0, 2047));
         5: queue_beat(KIND_CENTER, $urandom_range(0, 7), $urandom_range(0, 2047));
         6: queue_beat(KIND_UNUSED, $urandom_range(0, 7), $urandom_range(0, 2047));
         7: queue_beat(KIND_SET, 7, $urandom_range(0, 2047));
         default: queue_tick();
      endcase
   endtask

   // Tick the running frame out, with a few commands mixed in.
   task automatic settle_frame(input bit press);
      int r;
      wait_quiet();
      while (m_busy) begin
         r = frame_ticks_left();
         for (int i = 0; i < r; i++) begin
            if ($urandom_range(0, 99) < 12) queue_mid_cmd();
            else queue_tick();
         end
         if (press) begin
            hold_arm = 1'b1;
            press    = 1'b0;
         end
         wait_quiet();
      end
   endtask

   // Unless the widths are kept, give the framed channels short pulses; then start a frame and finish it.
   task automatic run_frame(input bit keep, input bit press);
      int t;
      int w;
      int sum;
      if (!keep) begin
         for (int ch = 0; ch < used_ch(); ch++) begin
            t = $urandom_range(0, 12);
            w = t;
            if (m_mask[ch]) begin
               // Mirrored width ends near t, or below zero now and then.
               sum = int'(m_max) + int'(m_min);
               w   = sum - t;
               if ($urandom_range(0, 3) == 0) w = sum + $urandom_range(1, 60);
            end
            if (w > WIDTH_TOP) w = WIDTH_TOP;
            if (w < -1024) w = -1024;
            queue_beat(KIND_SET, ch, w);
         end
      end
      queue_beat(KIND_START, $urandom_range(0, 7), $urandom_range(0, 2047));
      settle_frame(press);
   endtask

   // Random beats of any kind but start, all fields free.
   task automatic run_noise(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 6);
         if (k == KIND_START) k = KIND_UNUSED;
         queue_beat(k[KIND_W-1:0], $urandom_range(0, 7), $urandom_range(0, 2047));
      end
      wait_quiet();
   endtask

   initial begin
      int mark;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the register defaults.
      queue_beat(KIND_TICK, 0, 0);           // tick with no frame running
      queue_beat(KIND_UNUSED, 3, -1);
      queue_beat(KIND_SET, 0, 1023);
      queue_beat(KIND_SET, 1, -1024);        // saturates to zero
      queue_beat(KIND_SET, 7, 5);            // channel out of range
      queue_beat(KIND_SET, 6, 0);
      queue_beat(KIND_ANGLE, 2, 1023);
      queue_beat(KIND_ANGLE, 3, -1024);      // negative, saturates to zero
      queue_beat(KIND_ANGLE, 4, -1);         // quotient truncates toward zero
      queue_beat(KIND_ANGLE, 7, 100);
      queue_beat(KIND_CENTER, 0, 0);
      queue_beat(KIND_SET, 0, 200);
      queue_beat(KIND_UP, 0, 0);             // blocked at the ceiling
      queue_beat(KIND_SET, 1, 100);
      queue_beat(KIND_DOWN, 1, 0);           // blocked at the floor
      queue_beat(KIND_UP, 1, 0);
      queue_beat(KIND_DOWN, 0, 0);
      queue_beat(KIND_UP, 7, 0);
      queue_beat(KIND_DOWN, 7, 0);
      queue_beat(KIND_SET, 0, 0);
      queue_beat(KIND_SET, 1, 0);
      queue_beat(KIND_START, 0, 0);
      queue_beat(KIND_START, 0, 0);          // ignored while the frame runs
      queue_beat(KIND_SET, 1, 5);            // next pulse picks this up
      settle_frame(1'b0);

      // Register settings, extremes among them, each with its own stimulus.
      for (int p = 1; p <= 7; p++) begin
         wait_quiet();
         repeat (40) @(posedge clock);
         case (p)
            1: set_config(3, 7'b0000101, 0, 30, 10, 1);
            2: set_config(7, 7'b1111111, 5, 25, 15, 1023);
            3: set_config(1, 0, 0, 1023, 0, 1023);
            4: set_config(0, 0, 1023, 1023, 1023, 0);    // no frames, no angle term
            5: set_config(4, 7'b1010101, 20, 10, 5, 7);  // floor above ceiling
            6: set_config($urandom_range(1, 7), $urandom_range(0, 127), $urandom_range(0, 60),
                          $urandom_range(0, 60), $urandom_range(0, 60),
                          $urandom_range(1, 1023));
            default: set_config(1, 1, 700, 700, 700, 1023);
         endcase
         if (p == 7) begin
            // Mirrored width saturates at the top: one long pulse.
            queue_beat(KIND_SET, 0, 0);
            run_frame(1'b1, 1'b0);
            run_noise(30);
         end else begin
            mark = n_pushed;
            while (n_pushed - mark < PHASE_BEATS) begin
               // The long hold-off rides on the first full frame of all channels.
               if ((p == 2 && !hold_arm) || $urandom_range(0, 99) < 60)
                  run_frame(1'b0, p == 2 && !hold_arm);
               else run_noise($urandom_range(10, 40));
            end
         end
      end

      wait_quiet();
      repeat (60) @(posedge clock);
      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
